>>> rtl/core/mswq_pkg.sv
// Shared types, codes and helper function of the ordered wait queue block.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
package mswq_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_ID_BITS     = 8;

  // Configuration register indexes
  localparam logic [1:0] CFG_MODE  = 2'd0;
  localparam logic [1:0] CFG_ROAD  = 2'd1;
  localparam logic [1:0] CFG_SPEED = 2'd2;

  // Reset values of the configuration registers
  localparam logic [2:0]  RST_MODE  = 3'd0;
  localparam logic [15:0] RST_ROAD  = 16'd50;
  localparam logic [7:0]  RST_SPEED = 8'd10;

  // Scheduling modes
  localparam logic [2:0] MODE_FCFS = 3'd0;
  localparam logic [2:0] MODE_RR   = 3'd1;
  localparam logic [2:0] MODE_PRIO = 3'd2;
  localparam logic [2:0] MODE_SJF  = 3'd3;
  localparam logic [2:0] MODE_RT   = 3'd4;

  // Job classes
  localparam logic [1:0] CLS_NORMAL = 2'd0;
  localparam logic [1:0] CLS_SPORT  = 2'd1;
  localparam logic [1:0] CLS_EMERG  = 2'd2;

  // Result status codes
  localparam logic [1:0] RES_OK    = 2'd0;
  localparam logic [1:0] RES_EMPTY = 2'd1;
  localparam logic [1:0] RES_FULL  = 2'd2;

  typedef enum logic [1:0] {
    REQ_ENQ    = 2'd0,
    REQ_DEQ    = 2'd1,
    REQ_PEEK   = 2'd2,
    REQ_STATUS = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INSERT,
    S_HEAD_RD,
    S_HEAD_CHK,
    S_DONE
  } state_t;

  // Which queue offset addresses the entry store
  typedef enum logic [2:0] {
    ADDR_HEAD,
    ADDR_IDX,
    ADDR_K_PREV,
    ADDR_K,
    ADDR_POS
  } addr_sel_t;

  typedef struct packed {
    logic      latch_req;
    logic      div_start;
    logic      div_step;
    logic      idx_inc;
    logic      pos_from_n;
    logic      pos_from_idx;
    logic      k_dec;
    logic      ram_re;
    logic      ram_we;
    addr_sel_t addr_sel;
    logic      wdata_new;
    logic      head_capture;
    logic      pop;
    logic      push;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic full;
    logic empty;
    logic scan_needed;
    logic mode_sjf;
    logic idx_at_n;
    logic pass;
    logic k_at_pos;
    logic div_last;
  } sts_t;

  // Order of class weights 10 / 5 / 1 kept as a rank
  function automatic logic [1:0] class_rank(input logic [1:0] cls);
    logic [1:0] r;
    begin
      case (cls)
        CLS_EMERG: r = 2'd2;
        CLS_SPORT: r = 2'd1;
        default:   r = 2'd0;
      endcase
      return r;
    end
  endfunction

endpackage

>>> rtl/core/mswq_ram.sv
// Generic simple dual-port RAM with registered read data.
// No dependencies.
module mswq_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/mswq_ctrl.sv
// Sequencing state machine of the ordered wait queue block.
// Depends on mswq_pkg; drives the datapath by command struct only.
module mswq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  mswq_pkg::sts_t sts,
  output mswq_pkg::cmd_t cmd
);

  mswq_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mswq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      mswq_pkg::S_IDLE: begin
        if (in_valid) state_next = mswq_pkg::S_DECODE;
      end
      mswq_pkg::S_DECODE: begin
        unique case (sts.req)
          mswq_pkg::REQ_ENQ: begin
            if (sts.full)             state_next = mswq_pkg::S_DONE;
            else if (sts.mode_sjf)    state_next = mswq_pkg::S_DIV;
            else if (sts.scan_needed) state_next = mswq_pkg::S_SCAN_RD;
            else                      state_next = mswq_pkg::S_SHIFT_RD;
          end
          mswq_pkg::REQ_DEQ, mswq_pkg::REQ_PEEK: begin
            if (sts.empty) state_next = mswq_pkg::S_DONE;
            else           state_next = mswq_pkg::S_HEAD_RD;
          end
          default: state_next = mswq_pkg::S_DONE;
        endcase
      end
      mswq_pkg::S_DIV: begin
        if (sts.div_last) state_next = mswq_pkg::S_SCAN_RD;
      end
      mswq_pkg::S_SCAN_RD: begin
        if (sts.idx_at_n) state_next = mswq_pkg::S_SHIFT_RD;
        else              state_next = mswq_pkg::S_SCAN_CHK;
      end
      mswq_pkg::S_SCAN_CHK: begin
        if (sts.pass) state_next = mswq_pkg::S_SCAN_RD;
        else          state_next = mswq_pkg::S_SHIFT_RD;
      end
      mswq_pkg::S_SHIFT_RD: begin
        if (sts.k_at_pos) state_next = mswq_pkg::S_INSERT;
        else              state_next = mswq_pkg::S_SHIFT_WR;
      end
      mswq_pkg::S_SHIFT_WR: state_next = mswq_pkg::S_SHIFT_RD;
      mswq_pkg::S_INSERT:   state_next = mswq_pkg::S_DONE;
      mswq_pkg::S_HEAD_RD:  state_next = mswq_pkg::S_HEAD_CHK;
      mswq_pkg::S_HEAD_CHK: state_next = mswq_pkg::S_DONE;
      mswq_pkg::S_DONE: begin
        if (!out_valid || out_ready) state_next = mswq_pkg::S_IDLE;
      end
      default: state_next = mswq_pkg::S_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd = '0;
    cmd.addr_sel = mswq_pkg::ADDR_HEAD;
    unique case (state)
      mswq_pkg::S_IDLE: begin
        cmd.latch_req = in_valid;
      end
      mswq_pkg::S_DECODE: begin
        cmd.div_start = 1'b1;
        // tail placement needs no scan
        if (sts.req == mswq_pkg::REQ_ENQ && !sts.full && !sts.mode_sjf && !sts.scan_needed)
          cmd.pos_from_n = 1'b1;
      end
      mswq_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
      end
      mswq_pkg::S_SCAN_RD: begin
        cmd.addr_sel = mswq_pkg::ADDR_IDX;
        if (sts.idx_at_n) cmd.pos_from_idx = 1'b1;
        else              cmd.ram_re = 1'b1;
      end
      mswq_pkg::S_SCAN_CHK: begin
        if (sts.pass) cmd.idx_inc = 1'b1;
        else          cmd.pos_from_idx = 1'b1;
      end
      mswq_pkg::S_SHIFT_RD: begin
        cmd.addr_sel = mswq_pkg::ADDR_K_PREV;
        cmd.ram_re   = !sts.k_at_pos;
      end
      mswq_pkg::S_SHIFT_WR: begin
        cmd.addr_sel = mswq_pkg::ADDR_K;
        cmd.ram_we   = 1'b1;
        cmd.k_dec    = 1'b1;
      end
      mswq_pkg::S_INSERT: begin
        cmd.addr_sel  = mswq_pkg::ADDR_POS;
        cmd.ram_we    = 1'b1;
        cmd.wdata_new = 1'b1;
        cmd.push      = 1'b1;
      end
      mswq_pkg::S_HEAD_RD: begin
        cmd.ram_re = 1'b1;
      end
      mswq_pkg::S_HEAD_CHK: begin
        cmd.head_capture = 1'b1;
        cmd.pop          = (sts.req == mswq_pkg::REQ_DEQ);
      end
      mswq_pkg::S_DONE: begin
        cmd.out_load = !out_valid || out_ready;
      end
      default: cmd = '0;
    endcase
  end

  assign in_ready = (state == mswq_pkg::S_IDLE);

  // Output valid: set on load, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

>>> rtl/core/mswq_datapath.sv
// Datapath of the ordered wait queue block: registers, counters, divider,
// placement test and entry store. Depends on mswq_pkg and mswq_ram.
module mswq_datapath #(
  parameter int QUEUE_DEPTH = mswq_pkg::DEF_QUEUE_DEPTH,
  parameter int ID_BITS     = mswq_pkg::DEF_ID_BITS,
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic [1:0]         req_type,
  input  logic               direction,
  input  logic [ID_BITS-1:0] job_id,
  input  logic [1:0]         job_class,
  input  mswq_pkg::cmd_t     cmd,
  output mswq_pkg::sts_t     sts,
  output logic [1:0]         status,
  output logic [ID_BITS-1:0] head_id,
  output logic [1:0]         head_class,
  output logic [CW-1:0]      queue_length,
  output logic [CW-1:0]      emergency_waiting
);

  localparam int SW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int AW   = SW + 1;
  localparam int EW   = ID_BITS + 2;
  localparam int SUMW = CW + 1;

  // Configuration registers
  logic [2:0]  sched_mode;
  logic [15:0] trip_len;
  logic [7:0]  speed_div;

  always_ff @(posedge clk) begin
    if (rst) begin
      sched_mode <= mswq_pkg::RST_MODE;
      trip_len   <= mswq_pkg::RST_ROAD;
      speed_div  <= mswq_pkg::RST_SPEED;
    end else if (cfg_we) begin
      case (cfg_index)
        mswq_pkg::CFG_MODE:  sched_mode <= cfg_data[2:0];
        mswq_pkg::CFG_ROAD:  trip_len   <= cfg_data;
        mswq_pkg::CFG_SPEED: speed_div  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Latched transaction
  mswq_pkg::req_t     req_q;
  logic               dir_q;
  logic [ID_BITS-1:0] id_q;
  logic [1:0]         cls_q;

  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req_q <= mswq_pkg::req_t'(req_type);
      dir_q <= direction;
      id_q  <= job_id;
      cls_q <= job_class;
    end
  end

  // Per-queue counts and head pointers
  logic [CW-1:0] cnt  [2];
  logic [CW-1:0] emg  [2];
  logic [SW-1:0] head [2];
  logic [CW-1:0] n;
  logic [EW-1:0] rdata;
  logic [1:0]    rd_cls;

  assign n      = cnt[dir_q];
  assign rd_cls = rdata[1:0];

  // Offset within a queue to store slot, wrapping around the ring
  function automatic logic [SW-1:0] slot_of(input logic [SW-1:0] hd, input logic [CW-1:0] off);
    logic [SUMW-1:0] s;
    begin
      s = SUMW'(hd) + SUMW'(off);
      if (s >= SUMW'(QUEUE_DEPTH)) s = s - SUMW'(QUEUE_DEPTH);
      return s[SW-1:0];
    end
  endfunction

  logic [SW-1:0] hd_next;
  assign hd_next = slot_of(head[dir_q], CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt[0]  <= '0;
      cnt[1]  <= '0;
      emg[0]  <= '0;
      emg[1]  <= '0;
      head[0] <= '0;
      head[1] <= '0;
    end else if (cmd.push) begin
      cnt[dir_q] <= n + CW'(1);
      if (cls_q == mswq_pkg::CLS_EMERG) emg[dir_q] <= emg[dir_q] + CW'(1);
    end else if (cmd.pop) begin
      cnt[dir_q]  <= n - CW'(1);
      head[dir_q] <= hd_next;
      if (rd_cls == mswq_pkg::CLS_EMERG && emg[dir_q] != '0)
        emg[dir_q] <= emg[dir_q] - CW'(1);
    end
  end

  // Scan index, shift index and insertion point
  logic [CW-1:0] idx, k, pos;

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + CW'(1);
    end
    if (cmd.pos_from_n) begin
      pos <= n;
      k   <= n;
    end else if (cmd.pos_from_idx) begin
      pos <= idx;
      k   <= n;
    end else if (cmd.k_dec) begin
      k <= k - CW'(1);
    end
  end

  // Serial divider: trip length over speed divisor times 1, 2 and 3
  logic [15:0] est0, est1, est2;
  logic [1:0]  div_sel;
  logic [3:0]  div_cnt;
  logic [9:0]  div_rem;
  logic [15:0] div_quo;
  logic [9:0]  divisor;
  logic [10:0] rem_sh;
  logic        div_ge;
  logic [15:0] quo_fin;

  always_comb begin
    case (div_sel)
      2'd0:    divisor = {2'b00, speed_div};
      2'd1:    divisor = {1'b0, speed_div, 1'b0};
      default: divisor = {2'b00, speed_div} + {1'b0, speed_div, 1'b0};
    endcase
  end

  assign rem_sh  = {div_rem, trip_len[~div_cnt]};
  assign div_ge  = (rem_sh >= {1'b0, divisor});
  // zero speed saturates the estimate
  assign quo_fin = (divisor == '0) ? 16'hFFFF : {div_quo[14:0], div_ge};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_sel <= '0;
      div_cnt <= '0;
      div_rem <= '0;
    end else if (cmd.div_step) begin
      div_quo <= {div_quo[14:0], div_ge};
      div_rem <= div_ge ? 10'(rem_sh - {1'b0, divisor}) : rem_sh[9:0];
      div_cnt <= div_cnt + 4'd1;
      if (div_cnt == 4'd15) begin
        div_rem <= '0;
        div_sel <= div_sel + 2'd1;
        case (div_sel)
          2'd0:    est0 <= quo_fin;
          2'd1:    est1 <= quo_fin;
          default: est2 <= quo_fin;
        endcase
      end
    end
  end

  function automatic logic [15:0] est_of(input logic [1:0] cls, input logic [15:0] e0,
                                         input logic [15:0] e1, input logic [15:0] e2);
    logic [15:0] e;
    begin
      case (cls)
        mswq_pkg::CLS_SPORT: e = e1;
        mswq_pkg::CLS_EMERG: e = e2;
        default:             e = e0;
      endcase
      return e;
    end
  endfunction

  // Placement test of the stored entry against the new one
  logic pass;

  always_comb begin
    case (sched_mode)
      mswq_pkg::MODE_PRIO:
        pass = mswq_pkg::class_rank(rd_cls) >= mswq_pkg::class_rank(cls_q);
      mswq_pkg::MODE_SJF:
        pass = est_of(rd_cls, est0, est1, est2) <= est_of(cls_q, est0, est1, est2);
      default:
        pass = (rd_cls == mswq_pkg::CLS_EMERG);
    endcase
  end

  // Status to the controller
  always_comb begin
    sts.req         = req_q;
    sts.full        = (n == CW'(QUEUE_DEPTH));
    sts.empty       = (n == '0);
    sts.mode_sjf    = (sched_mode == mswq_pkg::MODE_SJF);
    sts.scan_needed = (sched_mode == mswq_pkg::MODE_PRIO) ||
                      (sched_mode == mswq_pkg::MODE_SJF) ||
                      (sched_mode == mswq_pkg::MODE_RT && cls_q == mswq_pkg::CLS_EMERG);
    sts.idx_at_n    = (idx == n);
    sts.pass        = pass;
    sts.k_at_pos    = (k == pos);
    sts.div_last    = (div_sel == 2'd2) && (div_cnt == 4'd15);
  end

  // Entry store address
  logic [CW-1:0] off;
  logic [AW-1:0] addr;

  always_comb begin
    case (cmd.addr_sel)
      mswq_pkg::ADDR_IDX:    off = idx;
      mswq_pkg::ADDR_K_PREV: off = k - CW'(1);
      mswq_pkg::ADDR_K:      off = k;
      mswq_pkg::ADDR_POS:    off = pos;
      default:               off = '0;
    endcase
  end

  assign addr = {dir_q, slot_of(head[dir_q], off)};

  mswq_ram #(
    .WIDTH (EW),
    .DEPTH (2 ** AW)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.ram_we),
    .waddr (addr),
    .wdata (cmd.wdata_new ? {id_q, cls_q} : rdata),
    .re    (cmd.ram_re),
    .raddr (addr),
    .rdata (rdata)
  );

  // Head capture and result register
  logic [ID_BITS-1:0] hid;
  logic [1:0]         hcls;
  logic [1:0]         res;

  always_comb begin
    res = mswq_pkg::RES_OK;
    if (req_q == mswq_pkg::REQ_ENQ && sts.full) res = mswq_pkg::RES_FULL;
    else if ((req_q == mswq_pkg::REQ_DEQ || req_q == mswq_pkg::REQ_PEEK) && sts.empty)
      res = mswq_pkg::RES_EMPTY;
  end

  logic [1:0] res_q;

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      hid   <= '0;
      hcls  <= '0;
      res_q <= res;
    end else if (cmd.head_capture) begin
      hid  <= rdata[EW-1:2];
      hcls <= rd_cls;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status            <= res_q;
      head_id           <= hid;
      head_class        <= hcls;
      queue_length      <= n;
      emergency_waiting <= emg[dir_q];
    end
  end

endmodule

>>> rtl/core/mode_selectable_ordered_wait_queue_top.sv
// Top level of the mode-selectable ordered wait queue block.
// Depends on mswq_pkg, mswq_ctrl and mswq_datapath.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  request  | in_valid / in_ready  | req_type, direction, job_id, job_class
//  result   | out_valid/out_ready  | status, head_id, head_class, queue_length,
//           |                      | emergency_waiting
//  config   | cfg_we               | cfg_index, cfg_data
//
// Status requests and rejected requests go straight to the result; dequeue and
// peek read the head first. Enqueue moves each entry behind the insertion point
// up one slot, after the placement scan has read the entries it passes; in
// shortest job mode a serial divider for the three estimates runs first. The
// single entry-store address sets the scan and shift steps. One transaction is in
// work at a time; a finished result waits in the output register while the
// next request is taken, and a result still not taken holds the last step.
// Reset empties both queues.
module mode_selectable_ordered_wait_queue_top #(
  parameter int QUEUE_DEPTH = mswq_pkg::DEF_QUEUE_DEPTH,
  parameter int ID_BITS     = mswq_pkg::DEF_ID_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [15:0]                        cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         req_type,
  input  logic                               direction,
  input  logic [ID_BITS-1:0]                 job_id,
  input  logic [1:0]                         job_class,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         status,
  output logic [ID_BITS-1:0]                 head_id,
  output logic [1:0]                         head_class,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]   queue_length,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]   emergency_waiting
);

  mswq_pkg::cmd_t cmd;
  mswq_pkg::sts_t sts;

  mswq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mswq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .req_type          (req_type),
    .direction         (direction),
    .job_id            (job_id),
    .job_class         (job_class),
    .cmd               (cmd),
    .sts               (sts),
    .status            (status),
    .head_id           (head_id),
    .head_class        (head_class),
    .queue_length      (queue_length),
    .emergency_waiting (emergency_waiting)
  );

endmodule

>>> rtl/core/mswq_checker.sv
// Port-level checks of the ordered wait queue block, bound to the top level.
// Depends on mswq_pkg.
module mswq_checker #(
  parameter int QUEUE_DEPTH = mswq_pkg::DEF_QUEUE_DEPTH,
  parameter int ID_BITS     = mswq_pkg::DEF_ID_BITS
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             cfg_we,
  input logic [1:0]                       cfg_index,
  input logic [15:0]                      cfg_data,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic [1:0]                       req_type,
  input logic                             direction,
  input logic [ID_BITS-1:0]               job_id,
  input logic [1:0]                       job_class,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [1:0]                       status,
  input logic [ID_BITS-1:0]               head_id,
  input logic [1:0]                       head_class,
  input logic [$clog2(QUEUE_DEPTH+1)-1:0] queue_length,
  input logic [$clog2(QUEUE_DEPTH+1)-1:0] emergency_waiting
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(head_id))
    else $error("result changed while stalled");

  // Take one transaction at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // Empty result carries no head and a zero length
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == mswq_pkg::RES_EMPTY |->
      head_id == '0 && head_class == '0 && queue_length == '0)
    else $error("empty result inconsistent");

  // Emergency count never exceeds the length
  a_emerg: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> emergency_waiting <= queue_length)
    else $error("emergency count above length");

  // Full result reports a full queue
  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == mswq_pkg::RES_FULL |->
      queue_length == ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
    else $error("full result with spare room");

endmodule

bind mode_selectable_ordered_wait_queue_top mswq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH),
  .ID_BITS     (ID_BITS)
) u_mswq_checker (.*);

>>> dv/tb_mode_selectable_ordered_wait_queue_top.sv
// Testbench for the mode-selectable ordered wait queue block: random and directed
// requests under random idling, with results checked against a software queue predictor.
// Depends on mswq_pkg and mode_selectable_ordered_wait_queue_top.
`timescale 1ns / 1ps

// Tracks both wait queues and holds the results still to come
class wait_queue_scoreboard;
  logic [2:0]  mode;
  logic [15:0] road;
  logic [7:0]  speed;
  logic [9:0]  lanes [2][$];
  int          emerg_cnt [2];
  logic [21:0] pending [$];
  int          mismatches;

  function void clear();
    mode = mswq_pkg::RST_MODE;
    road = mswq_pkg::RST_ROAD;
    speed = mswq_pkg::RST_SPEED;
    lanes[0].delete();
    lanes[1].delete();
    emerg_cnt[0] = 0;
    emerg_cnt[1] = 0;
    pending.delete();
    mismatches = 0;
  endfunction

  function int weight(logic [1:0] cls);
    if (cls == mswq_pkg::CLS_EMERG) return 10;
    if (cls == mswq_pkg::CLS_SPORT) return 5;
    return 1;
  endfunction

  function int travel_estimate(logic [1:0] cls);
    int mult;
    int div;
    mult = (cls == mswq_pkg::CLS_SPORT) ? 2 : (cls == mswq_pkg::CLS_EMERG) ? 3 : 1;
    div = speed * mult;
    if (div == 0) return 65535;
    return road / div;
  endfunction

  function int slot_for(int d, logic [1:0] cls);
    int pos;
    int n;
    pos = 0;
    n = lanes[d].size();
    case (mode)
      mswq_pkg::MODE_PRIO:
        while (pos < n && weight(lanes[d][pos][1:0]) >= weight(cls)) pos++;
      mswq_pkg::MODE_SJF:
        while (pos < n && travel_estimate(lanes[d][pos][1:0]) <= travel_estimate(cls)) pos++;
      mswq_pkg::MODE_RT: begin
        if (cls != mswq_pkg::CLS_EMERG) pos = n;
        else while (pos < n && lanes[d][pos][1:0] == mswq_pkg::CLS_EMERG) pos++;
      end
      default: pos = n;
    endcase
    return pos;
  endfunction

  // Apply one accepted request and queue its expected result
  function void note_request(logic [1:0] req, logic dir, logic [7:0] id, logic [1:0] cls);
    logic [1:0] st;
    logic [7:0] hid;
    logic [1:0] hcls;
    int d;
    d = dir;
    st = mswq_pkg::RES_OK;
    hid = '0;
    hcls = '0;
    if (req == mswq_pkg::REQ_ENQ) begin
      if (lanes[d].size() >= 16) st = mswq_pkg::RES_FULL;
      else begin
        lanes[d].insert(slot_for(d, cls), {id, cls});
        if (cls == mswq_pkg::CLS_EMERG) emerg_cnt[d]++;
      end
    end else if (req == mswq_pkg::REQ_DEQ || req == mswq_pkg::REQ_PEEK) begin
      if (lanes[d].size() == 0) st = mswq_pkg::RES_EMPTY;
      else begin
        hid = lanes[d][0][9:2];
        hcls = lanes[d][0][1:0];
        if (req == mswq_pkg::REQ_DEQ) begin
          void'(lanes[d].pop_front());
          if (hcls == mswq_pkg::CLS_EMERG && emerg_cnt[d] > 0) emerg_cnt[d]--;
        end
      end
    end
    pending.push_back({st, hid, hcls, 5'(lanes[d].size()), 5'(emerg_cnt[d])});
  endfunction

  function void check_result(logic [21:0] got);
    logic [21:0] want;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch st/id/cls/len/em: expected %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                 want[21:20], want[19:12], want[11:10], want[9:5], want[4:0],
                 got[21:20], got[19:12], got[11:10], got[9:5], got[4:0]);
    end
  endfunction
endclass

module tb_mode_selectable_ordered_wait_queue_top;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  req_type;
  logic        direction;
  logic [7:0]  job_id;
  logic [1:0]  job_class;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic [7:0]  head_id;
  logic [1:0]  head_class;
  logic [4:0]  queue_length;
  logic [4:0]  emergency_waiting;

  wait_queue_scoreboard board;
  int  hold_off;
  bit  directed_done;

  mode_selectable_ordered_wait_queue_top DUT (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Limit on the whole run
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  // Offer one request and hold it until the block takes it
  task automatic send_request(logic [1:0] req, logic dir, logic [7:0] id, logic [1:0] cls);
    int gap;
    gap = $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    direction <= dir;
    job_id <= id;
    job_class <= cls;
    do @(posedge clk); while (!in_ready);
    board.note_request(req, dir, id, cls);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      mswq_pkg::CFG_MODE: board.mode = val[2:0];
      mswq_pkg::CFG_ROAD: board.road = val;
      default:            board.speed = val[7:0];
    endcase
    @(negedge clk);
  endtask

  // Drain every expected result before touching the registers
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic random_request(int enq_bias);
    logic [1:0] req;
    req = ($urandom_range(0, 99) < enq_bias) ? mswq_pkg::REQ_ENQ : 2'($urandom_range(1, 3));
    send_request(req, 1'($urandom), 8'($urandom), 2'($urandom));
  endtask

  // Receiver: random stalls, one long hold-off on request
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off > 0) begin
        out_ready <= 1'b0;
        repeat (hold_off) @(negedge clk);
        hold_off = 0;
      end
      stall = (directed_done && $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      board.check_result({status, head_id, head_class, queue_length, emergency_waiting});
      @(negedge clk);
    end
  end

  initial begin
    logic [2:0] modes [8];
    int i;
    int p;
    board = new();
    board.clear();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = mswq_pkg::CFG_MODE;
    cfg_data = '0;
    in_valid = 1'b0;
    req_type = mswq_pkg::REQ_STATUS;
    direction = 1'b0;
    job_id = '0;
    job_class = mswq_pkg::CLS_NORMAL;
    hold_off = 0;
    directed_done = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty queues, extremes of the fields, class three, then a full left queue
    send_request(mswq_pkg::REQ_DEQ, 1'b0, 8'hff, 2'd3);
    send_request(mswq_pkg::REQ_PEEK, 1'b1, 8'h00, mswq_pkg::CLS_EMERG);
    send_request(mswq_pkg::REQ_STATUS, 1'b0, 8'hff, mswq_pkg::CLS_SPORT);
    for (i = 0; i < 17; i++) send_request(mswq_pkg::REQ_ENQ, 1'b0, 8'(i * 15), 2'(i));
    send_request(mswq_pkg::REQ_PEEK, 1'b0, 8'd0, mswq_pkg::CLS_NORMAL);
    send_request(mswq_pkg::REQ_DEQ, 1'b0, 8'd0, mswq_pkg::CLS_NORMAL);
    send_request(mswq_pkg::REQ_ENQ, 1'b1, 8'hff, 2'd3);
    wait_idle();
    directed_done = 1'b1;

    // Phases across modes, an unknown mode and register extremes
    modes = '{mswq_pkg::MODE_FCFS, mswq_pkg::MODE_RR, mswq_pkg::MODE_PRIO, mswq_pkg::MODE_SJF,
              mswq_pkg::MODE_RT, 3'd7, mswq_pkg::MODE_SJF, mswq_pkg::MODE_PRIO};
    for (p = 0; p < 8; p++) begin
      write_reg(mswq_pkg::CFG_MODE, 16'(modes[p]));
      case (p)
        3: begin
          write_reg(mswq_pkg::CFG_ROAD, 16'hffff);
          write_reg(mswq_pkg::CFG_SPEED, 16'd1);
        end
        5: begin
          write_reg(mswq_pkg::CFG_ROAD, 16'd0);
          write_reg(mswq_pkg::CFG_SPEED, 16'd255);
        end
        6: begin
          write_reg(mswq_pkg::CFG_ROAD, 16'($urandom));
          write_reg(mswq_pkg::CFG_SPEED, 16'd0);
        end
        7: begin
          write_reg(mswq_pkg::CFG_ROAD, 16'd1000);
          write_reg(mswq_pkg::CFG_SPEED, 16'd7);
        end
        default: ;
      endcase
      if (p == 2) hold_off = 300;
      for (i = 0; i < 230; i++) random_request((i % 60 < 30) ? 70 : 30);
      wait_idle();
    end

    while (board.pending.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

>>> mode_selectable_ordered_wait_queue_top.f
rtl/core/mswq_pkg.sv
rtl/core/mswq_ram.sv
rtl/core/mswq_ctrl.sv
rtl/core/mswq_datapath.sv
rtl/core/mode_selectable_ordered_wait_queue_top.sv
rtl/core/mswq_checker.sv
dv/tb_mode_selectable_ordered_wait_queue_top.sv
